// ----- hdl/cecfbt_pkg.sv -----
package cecfbt_pkg;

    typedef enum logic [2:0] {
        FN_LOAD,
        FN_REQUEST,
        FN_START,
        FN_NEXT_BIT,
        FN_ECHO,
        FN_ACK,
        FN_FINISH_ABORT,
        FN_HALT
    } func_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FAILED,
        PH_PEND,
        PH_AGAIN,
        PH_DATA,
        PH_ACK,
        PH_WAIT_ACK
    } phase_t;

    localparam logic [2:0] CFG_MAX_RETRIES  = 3'd0;
    localparam logic [2:0] CFG_RETRY_WAIT   = 3'd1;
    localparam logic [2:0] CFG_PRESENT_WAIT = 3'd2;
    localparam logic [2:0] CFG_NEW_WAIT     = 3'd3;
    localparam logic [2:0] CFG_ECHO_DELAY   = 3'd4;

    localparam logic [3:0] MAX_RETRIES_RST  = 4'd5;
    localparam logic [3:0] RETRY_WAIT_RST   = 4'd3;
    localparam logic [3:0] PRESENT_WAIT_RST = 4'd7;
    localparam logic [3:0] NEW_WAIT_RST     = 4'd5;
    localparam logic       ECHO_DELAY_RST   = 1'b1;

    localparam logic [7:0] TOP_BIT = 8'h80;

    typedef struct packed {
        func_t      func;
        logic [3:0] byte_index;
        logic [7:0] byte_value;
        logic [3:0] end_index;
        logic       echo_bit;
        logic       ack_seen;
    } evt_t;

    typedef struct packed {
        logic       tx_bit;
        phase_t     status;
        logic       abort_request;
        logic [3:0] idle_wait;
        logic [3:0] retry_count;
    } res_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] index;
        logic [3:0] data;
    } cfg_wr_t;

endpackage

// ----- hdl/cecfbt_frame_buf.sv -----
module cecfbt_frame_buf
    import cecfbt_pkg::*;
#(
    parameter int BUF_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       wr_en,
    input  logic [3:0] wr_index,
    input  logic [7:0] wr_data,
    input  logic [3:0] rd_pos,
    output logic [7:0] rd_data
);

    // only sixteen positions are reachable through a 4-bit index
    localparam int STORE_DEPTH = (BUF_DEPTH < 16) ? BUF_DEPTH : 16;
    localparam int AW          = $clog2(STORE_DEPTH);

    logic [7:0] store_reg [STORE_DEPTH];
    logic       wr_hit;
    logic       rd_hit;

    assign wr_hit = wr_en && (32'(wr_index) < BUF_DEPTH);
    assign rd_hit = 32'(rd_pos) < BUF_DEPTH;

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            store_reg[wr_index[AW-1:0]] <= wr_data;
        end
    end

    always_comb
    begin
        rd_data = rd_hit ? store_reg[rd_pos[AW-1:0]] : 8'h00;
    end

endmodule

// ----- hdl/cecfbt_engine.sv -----
module cecfbt_engine
    import cecfbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_wr_t    cfg,
    input  logic       fire,
    input  evt_t       evt,
    input  logic [7:0] rd_data,
    output logic [3:0] rd_pos,
    output res_t       result
);

    logic [3:0] max_retries_reg;
    logic [3:0] retry_wait_reg;
    logic [3:0] present_wait_reg;
    logic       echo_delay_reg;

    logic [3:0] last_index_reg,   last_index_next;
    logic [3:0] byte_pos_reg,     byte_pos_next;
    logic [7:0] bit_mask_reg,     bit_mask_next;
    phase_t     phase_reg,        phase_next;
    logic [3:0] retries_reg,      retries_next;
    logic [1:0] sent_history_reg, sent_history_next;
    logic [3:0] wait_periods_reg, wait_periods_next;

    logic       tx;
    logic       abort_req;
    logic       sending;
    logic       bit_out;
    logic       last;
    logic       echo_ref;

    assign rd_pos = byte_pos_reg;

    always_comb
    begin
        last_index_next   = last_index_reg;
        byte_pos_next     = byte_pos_reg;
        bit_mask_next     = bit_mask_reg;
        phase_next        = phase_reg;
        retries_next      = retries_reg;
        sent_history_next = sent_history_reg;
        wait_periods_next = wait_periods_reg;
        tx                = 1'b0;
        abort_req         = 1'b0;
        bit_out           = 1'b0;
        sending           = phase_reg inside {PH_DATA, PH_ACK, PH_WAIT_ACK};
        last              = byte_pos_reg == last_index_reg;
        echo_ref          = echo_delay_reg ? sent_history_reg[1] : sent_history_reg[0];

        case (evt.func)
            FN_LOAD:
            begin
            end
            FN_REQUEST:
            begin
                if (!sending)
                begin
                    last_index_next = evt.end_index;
                    phase_next      = PH_PEND;
                end
            end
            FN_START:
            begin
                if (phase_reg == PH_PEND)
                begin
                    retries_next = 4'd0;
                end
                bit_mask_next = TOP_BIT;
                byte_pos_next = 4'd0;
                phase_next    = PH_DATA;
            end
            FN_NEXT_BIT:
            begin
                if (sending)
                begin
                    if (bit_mask_reg != 8'h00)
                    begin
                        bit_out       = |(rd_data & bit_mask_reg);
                        bit_mask_next = bit_mask_reg >> 1;
                    end
                    else if (phase_reg == PH_DATA)
                    begin
                        // eom, never set for a ping
                        bit_out    = last && (last_index_reg != 4'd0);
                        phase_next = PH_ACK;
                    end
                    else
                    begin
                        bit_out = 1'b1;
                        if (last)
                        begin
                            phase_next = PH_WAIT_ACK;
                        end
                        else
                        begin
                            bit_mask_next = TOP_BIT;
                            byte_pos_next = byte_pos_reg + 4'd1;
                            phase_next    = PH_DATA;
                        end
                        wait_periods_next = present_wait_reg;
                    end
                    sent_history_next = {sent_history_reg[0], bit_out};
                    tx                = bit_out;
                end
                else
                begin
                    tx = 1'b1;
                end
            end
            FN_ECHO:
            begin
                abort_req = sending && (evt.echo_bit != echo_ref);
            end
            FN_ACK:
            begin
                if (evt.ack_seen)
                begin
                    if (phase_reg == PH_WAIT_ACK)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                else
                begin
                    abort_req = sending;
                end
            end
            FN_FINISH_ABORT:
            begin
                retries_next = retries_reg + 4'd1;
                if (retries_next == max_retries_reg)
                begin
                    phase_next = PH_FAILED;
                end
                else
                begin
                    wait_periods_next = retry_wait_reg;
                    phase_next        = PH_AGAIN;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        result.tx_bit        = tx;
        result.status        = phase_next;
        result.abort_request = abort_req;
        result.idle_wait     = wait_periods_next;
        result.retry_count   = retries_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg  <= MAX_RETRIES_RST;
            retry_wait_reg   <= RETRY_WAIT_RST;
            present_wait_reg <= PRESENT_WAIT_RST;
            echo_delay_reg   <= ECHO_DELAY_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MAX_RETRIES:  max_retries_reg  <= cfg.data;
                CFG_RETRY_WAIT:   retry_wait_reg   <= cfg.data;
                CFG_PRESENT_WAIT: present_wait_reg <= cfg.data;
                CFG_NEW_WAIT:
                begin
                    // new_wait writes are ignored; the value after reset is fixed at NEW_WAIT_RST
                end
                CFG_ECHO_DELAY:   echo_delay_reg   <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_index_reg   <= 4'd0;
            byte_pos_reg     <= 4'd0;
            bit_mask_reg     <= 8'h00;
            phase_reg        <= PH_IDLE;
            retries_reg      <= 4'd0;
            sent_history_reg <= 2'd0;
            wait_periods_reg <= NEW_WAIT_RST;
        end
        else if (fire)
        begin
            last_index_reg   <= last_index_next;
            byte_pos_reg     <= byte_pos_next;
            bit_mask_reg     <= bit_mask_next;
            phase_reg        <= phase_next;
            retries_reg      <= retries_next;
            sent_history_reg <= sent_history_next;
            wait_periods_reg <= wait_periods_next;
        end
    end

endmodule

// ----- hdl/cec_frame_bit_transmitter.sv -----
// CEC frame bit transmitter. One request per clock while the output side is
// not stalled: each request is one event (load byte, request, start, next bit,
// echo, ack, finish abort, halt) and produces exactly one result. The request
// is held in the input register, and its result enters the output register
// once the output side is not stalled. Each event takes a single registered
// pass from the input register through the event logic to the output
// register; the frame buffer is a flip-flop array read at
// the current byte position in that same pass and holds whatever was loaded,
// with no clearing after reset. Configuration writes are taken at any time and
// are meant to be made while no request is in flight.
module cec_frame_bit_transmitter
    import cecfbt_pkg::*;
#(
    parameter int BUF_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // byte_index, byte_value, end_index, echo_bit, ack_seen
    input  logic [2:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // tx_bit, status, abort_request, idle_wait, retry_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    logic       in_valid_reg;
    evt_t       in_evt_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;
    logic       fire;
    res_t       result;
    cfg_wr_t    cfg;
    logic [3:0] rd_pos;
    logic [7:0] rd_data;

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_evt_reg.func       <= func_t'(s_tuser);
            in_evt_reg.byte_index <= s_tdata[3:0];
            in_evt_reg.byte_value <= s_tdata[11:4];
            in_evt_reg.end_index  <= s_tdata[15:12];
            in_evt_reg.echo_bit   <= s_tdata[16];
            in_evt_reg.ack_seen   <= s_tdata[17];
        end
        if (fire)
        begin
            out_res_reg <= result;
        end
    end

    cecfbt_frame_buf #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_frame_buf (
        .clk      (clk),
        .wr_en    (fire && (in_evt_reg.func == FN_LOAD)),
        .wr_index (in_evt_reg.byte_index),
        .wr_data  (in_evt_reg.byte_value),
        .rd_pos   (rd_pos),
        .rd_data  (rd_data)
    );

    cecfbt_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .fire    (fire),
        .evt     (in_evt_reg),
        .rd_data (rd_data),
        .rd_pos  (rd_pos),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.retry_count,
                       out_res_reg.idle_wait,
                       out_res_reg.abort_request,
                       out_res_reg.status,
                       out_res_reg.tx_bit};

endmodule

// ----- hdl/cecfbt_checker.sv -----
module cecfbt_checker
    import cecfbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata
);

    logic [2:0] out_status;

    assign out_status = m_tdata[3:1];

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

    // with no result showing and no request accepted before, no result appears
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !$past(s_tvalid && s_tready) |=> !m_tvalid)
    else $error("result without request");

    // abort only while sending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |->
            out_status == PH_DATA || out_status == PH_ACK || out_status == PH_WAIT_ACK)
    else $error("abort outside a send");

    // abort comes from echo or ack, which drive no bit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> !m_tdata[0] && out_status != 3'd7)
    else $error("abort with driven bit");

endmodule

bind cec_frame_bit_transmitter cecfbt_checker u_checker (.*);
